@@ sv/swpm_pkg.sv @@
package swpm_pkg;

  // Window store depth; must be a power of two so the ring pointers wrap naturally.
  localparam int WINDOW_DEPTH = 1024;
  localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
  localparam int CNT_W        = ADDR_W + 1;

  // Field widths.
  localparam int TIME_W   = 34;
  localparam int ID_W     = 32;
  localparam int STATUS_W = 10;
  localparam int WIN_W    = 32;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 34;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW      = 2'd2;

  // Lowest status code that counts as a server error.
  localparam logic [STATUS_W-1:0] ERROR_STATUS = 10'd500;

  // Classified event passed from the front end to the window engine.
  typedef struct packed {
    logic [TIME_W-1:0] event_time;
    logic [ID_W-1:0]   line_id;
    logic              in_range;
    logic              server_error;
    logic              track;
  } item_t;

endpackage

@@ sv/sliding_window_peak_rate_monitor_top.sv @@
// Sliding-window peak event-rate monitor.
// Events enter on a queue-style port: a word is taken on a clock edge with push high
// and full low. Every event produces exactly one result word, in order, presented
// while empty is low and removed on an edge with pop high and empty low.
// Configuration (range start, range end, window length) is written through
// cfg_valid/cfg_ready with cfg_index 0, 1 or 2; cfg_ready is always high, and
// writes are meant for when no event is in flight.
// An event that is out of range or seen with the window disabled goes from idle
// straight to the emit state of the window engine; a tracked event passes the push,
// read and check states, with another read and check for each expired entry, since
// each expiry test waits on the registered read of the window store. Expiries are
// amortized at most one per event. A new event is taken only back in the idle state.
// A two-word queue sits on either side of the engine; when the consumer stalls,
// results collect there and then full rises on the input side.
// Synchronous reset clears the control state, the pointers, the counts, the peak and the
// overflow flag; the window store is not cleared, since no entry is read before it is written.
module sliding_window_peak_rate_monitor_top
  import swpm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  push,
  output logic                  full,
  input  logic [TIME_W-1:0]     event_time,
  input  logic [STATUS_W-1:0]   status_code,
  input  logic [ID_W-1:0]       line_id,
  output logic                  empty,
  input  logic                  pop,
  output logic                  in_range,
  output logic                  server_error,
  output logic [CNT_W-1:0]      window_count,
  output logic [CNT_W-1:0]      peak_count,
  output logic [ID_W-1:0]       peak_first_id,
  output logic [ID_W-1:0]       peak_last_id,
  output logic                  overflowed
);

  logic             q_wr;
  logic             q_full;
  logic             q_rd;
  logic             q_empty;
  item_t            q_in;
  item_t            q_out;
  logic [WIN_W-1:0] window_seconds;

  swpm_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .push           (push),
    .full           (full),
    .event_time     (event_time),
    .status_code    (status_code),
    .line_id        (line_id),
    .q_wr           (q_wr),
    .q_data         (q_in),
    .q_full         (q_full),
    .window_seconds (window_seconds)
  );

  swpm_link_q u_link_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_in),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_out),
    .empty (q_empty)
  );

  swpm_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_data         (q_out),
    .q_empty        (q_empty),
    .q_rd           (q_rd),
    .window_seconds (window_seconds),
    .empty          (empty),
    .pop            (pop),
    .in_range       (in_range),
    .server_error   (server_error),
    .window_count   (window_count),
    .peak_count     (peak_count),
    .peak_first_id  (peak_first_id),
    .peak_last_id   (peak_last_id),
    .overflowed     (overflowed)
  );

endmodule

@@ sv/swpm_front.sv @@
module swpm_front
  import swpm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Configuration writes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Event input.
  input  logic                  push,
  output logic                  full,
  input  logic [TIME_W-1:0]     event_time,
  input  logic [STATUS_W-1:0]   status_code,
  input  logic [ID_W-1:0]       line_id,
  // Toward the link queue.
  output logic                  q_wr,
  output item_t                 q_data,
  input  logic                  q_full,
  output logic [WIN_W-1:0]      window_seconds
);

  logic [TIME_W-1:0] range_start;
  logic [TIME_W-1:0] range_end;
  logic [WIN_W-1:0]  window_len;
  logic              in_range;

  assign cfg_ready = 1'b1;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      range_start <= '0;
      range_end   <= '1;
      window_len  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RANGE_START: range_start <= cfg_data[TIME_W-1:0];
        REG_RANGE_END:   range_end   <= cfg_data[TIME_W-1:0];
        REG_WINDOW:      window_len  <= cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Classify the incoming word.
  assign in_range = (range_start <= event_time) && (event_time <= range_end);

  always_comb begin
    q_data.event_time   = event_time;
    q_data.line_id      = line_id;
    q_data.in_range     = in_range;
    q_data.server_error = in_range && (status_code >= ERROR_STATUS);
    q_data.track        = in_range && (window_len != '0);
  end

  assign full           = q_full;
  assign q_wr           = push && !q_full;
  assign window_seconds = window_len;

endmodule

@@ sv/swpm_link_q.sv @@
module swpm_link_q
  import swpm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  item_t wdata,
  output logic  full,
  input  logic  rd,
  output item_t rdata,
  output logic  empty
);

  item_t      slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = slots[rp];

  // Two-entry queue so that the front end and the engine stall independently.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_wr) begin
        wp <= ~wp;
      end
      if (do_rd) begin
        rp <= ~rp;
      end
      if (do_wr && !do_rd) begin
        count <= count + 2'd1;
      end else if (do_rd && !do_wr) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

@@ sv/swpm_back.sv @@
module swpm_back
  import swpm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // From the link queue.
  input  item_t             q_data,
  input  logic              q_empty,
  output logic              q_rd,
  input  logic [WIN_W-1:0]  window_seconds,
  // Result queue toward the consumer.
  output logic              empty,
  input  logic              pop,
  output logic              in_range,
  output logic              server_error,
  output logic [CNT_W-1:0]  window_count,
  output logic [CNT_W-1:0]  peak_count,
  output logic [ID_W-1:0]   peak_first_id,
  output logic [ID_W-1:0]   peak_last_id,
  output logic              overflowed
);

  typedef struct packed {
    logic             in_range;
    logic             server_error;
    logic [CNT_W-1:0] window_count;
    logic [CNT_W-1:0] peak_count;
    logic [ID_W-1:0]  peak_first_id;
    logic [ID_W-1:0]  peak_last_id;
    logic             overflowed;
  } result_t;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PUSH  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(WINDOW_DEPTH);

  logic [2:0]        state;
  item_t             cur;
  logic [ADDR_W-1:0] head;
  logic [CNT_W-1:0]  occ;
  logic [CNT_W-1:0]  peak;
  logic [ID_W-1:0]   peak_first;
  logic [ID_W-1:0]   peak_last;
  logic              ovf;

  // Window store.
  logic [TIME_W-1:0] times [WINDOW_DEPTH];
  logic [ID_W-1:0]   ids   [WINDOW_DEPTH];
  logic [TIME_W-1:0] rd_time;
  logic [ID_W-1:0]   rd_id;
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr;

  // Result queue.
  result_t    res_slots [2];
  logic       res_wp;
  logic       res_rp;
  logic [1:0] res_cnt;
  logic       res_full;
  logic       res_wr;
  logic       res_rd;
  result_t    res_word;
  result_t    res_head;

  logic [TIME_W-1:0] age;
  logic              pop_oldest;
  logic              store_full;

  // The tail slot is head plus occupancy; when the store is full this is the old head,
  // which is exactly the slot freed by dropping the oldest entry.
  assign wr_addr    = head + occ[ADDR_W-1:0];
  assign store_full = (occ == DEPTH_CNT);
  assign mem_we     = (state == S_PUSH);

  // The store is read at the head pointer every cycle; the read data is registered.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      times[wr_addr] <= cur.event_time;
      ids[wr_addr]   <= cur.line_id;
    end
    rd_time <= times[head];
    rd_id   <= ids[head];
  end

  // Expiry test on the oldest entry; an older or equal time never expires.
  assign age        = cur.event_time - rd_time;
  assign pop_oldest = (occ > CNT_W'(1)) && (cur.event_time > rd_time) &&
                      (age > {{(TIME_W-WIN_W){1'b0}}, window_seconds});

  assign q_rd     = (state == S_IDLE) && !q_empty;
  assign res_full = (res_cnt == 2'd2);
  assign res_wr   = (state == S_EMIT) && !res_full;
  assign res_rd   = pop && !empty;

  always_comb begin
    res_word.in_range      = cur.in_range;
    res_word.server_error  = cur.server_error;
    res_word.window_count  = occ;
    res_word.peak_count    = peak;
    res_word.peak_first_id = peak_first;
    res_word.peak_last_id  = peak_last;
    res_word.overflowed    = ovf;
  end

  // Sequencer: take a word; for a tracked one push it, expire old entries and update the peak; report.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      occ        <= '0;
      peak       <= '0;
      peak_first <= '0;
      peak_last  <= '0;
      ovf        <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur   <= q_data;
            state <= q_data.track ? S_PUSH : S_EMIT;
          end
        end
        S_PUSH: begin
          if (store_full) begin
            head <= head + ADDR_W'(1);
            ovf  <= 1'b1;
          end else begin
            occ <= occ + CNT_W'(1);
          end
          state <= S_READ;
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (pop_oldest) begin
            head  <= head + ADDR_W'(1);
            occ   <= occ - CNT_W'(1);
            state <= S_READ;
          end else begin
            if (occ > peak) begin
              peak       <= occ;
              peak_first <= rd_id;
              peak_last  <= cur.line_id;
            end
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!res_full) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Two-entry result queue so the engine keeps going while the consumer stalls.
  always_ff @(posedge clk) begin
    if (res_wr) begin
      res_slots[res_wp] <= res_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wp  <= 1'b0;
      res_rp  <= 1'b0;
      res_cnt <= 2'd0;
    end else begin
      if (res_wr) begin
        res_wp <= ~res_wp;
      end
      if (res_rd) begin
        res_rp <= ~res_rp;
      end
      if (res_wr && !res_rd) begin
        res_cnt <= res_cnt + 2'd1;
      end else if (res_rd && !res_wr) begin
        res_cnt <= res_cnt - 2'd1;
      end
    end
  end

  assign empty         = (res_cnt == 2'd0);
  assign res_head      = res_slots[res_rp];
  assign in_range      = res_head.in_range;
  assign server_error  = res_head.server_error;
  assign window_count  = res_head.window_count;
  assign peak_count    = res_head.peak_count;
  assign peak_first_id = res_head.peak_first_id;
  assign peak_last_id  = res_head.peak_last_id;
  assign overflowed    = res_head.overflowed;

  // The occupancy never exceeds the store depth.
  a_occ_bound: assert property (@(posedge clk) disable iff (rst) occ <= DEPTH_CNT)
    else $error("window occupancy exceeds store depth");

  // Between words the peak is never below the current occupancy.
  a_peak_covers: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (peak >= occ))
    else $error("peak below occupancy while idle");

  // The overflow flag is sticky.
  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst) ovf |=> ovf)
    else $error("overflow flag cleared");

  // The head pointer only moves on a push into a full store or on an expiry.
  a_head_moves: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_READ || state == S_EMIT) |=> $stable(head))
    else $error("head pointer moved outside push or expiry");

  // A word is taken from the link queue only when no result is being built.
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    q_rd |=> (state == S_PUSH || state == S_EMIT))
    else $error("word taken without starting work on it");

endmodule

@@ test/peak_rate_checker.sv @@
module peak_rate_checker
  import swpm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  push,
  input  logic                  full,
  input  logic [TIME_W-1:0]     event_time,
  input  logic [STATUS_W-1:0]   status_code,
  input  logic [ID_W-1:0]       line_id,
  input  logic                  empty,
  input  logic                  pop,
  input  logic                  in_range,
  input  logic                  server_error,
  input  logic [CNT_W-1:0]      window_count,
  input  logic [CNT_W-1:0]      peak_count,
  input  logic [ID_W-1:0]       peak_first_id,
  input  logic [ID_W-1:0]       peak_last_id,
  input  logic                  overflowed,
  output int                    pending_reports,
  output int                    mismatches
);

  // One result word as the block reports it.
  typedef struct packed {
    logic             in_range;
    logic             server_error;
    logic [CNT_W-1:0] window_count;
    logic [CNT_W-1:0] peak_count;
    logic [ID_W-1:0]  first_id;
    logic [ID_W-1:0]  last_id;
    logic             overflowed;
  } report_t;

  // Configuration as last written.
  logic [TIME_W-1:0] lo_bound;
  logic [TIME_W-1:0] hi_bound;
  logic [WIN_W-1:0]  span;

  // Shadow of the window ring and of the peak bookkeeping.
  logic [TIME_W-1:0] ring_times [WINDOW_DEPTH];
  logic [ID_W-1:0]   ring_ids   [WINDOW_DEPTH];
  logic [ADDR_W-1:0] oldest_slot;
  logic [CNT_W-1:0]  held;
  logic [CNT_W-1:0]  peak_held;
  logic [ID_W-1:0]   peak_first;
  logic [ID_W-1:0]   peak_last;
  logic              dropped;

  report_t expected_reports [$];
  int      fail_tally = 0;

  assign mismatches = fail_tally;

  // Compare one field of a result word and count a mismatch.
  task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                             input logic [TIME_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_tally++;
    end
  endtask

  // Classify one event, slide the window over it and report the new state.
  task automatic advance_window(input logic [TIME_W-1:0] t, input logic [STATUS_W-1:0] status,
                                input logic [ID_W-1:0] id, output report_t rep);
    logic [ADDR_W-1:0] newest_slot;
    logic              hit;
    logic              expire;
    hit = (t >= lo_bound) && (t <= hi_bound);
    if (hit && span != '0) begin
      // A full ring drops its oldest entry to make room.
      if (held == CNT_W'(WINDOW_DEPTH)) begin
        oldest_slot++;
        held--;
        dropped = 1'b1;
      end
      newest_slot = oldest_slot + held[ADDR_W-1:0];
      ring_times[newest_slot] = t;
      ring_ids[newest_slot] = id;
      held++;
      // Expire old entries; an older newest time never expires anything.
      expire = 1'b1;
      while (held > 1 && expire) begin
        if (t > ring_times[oldest_slot] && (t - ring_times[oldest_slot]) > TIME_W'(span)) begin
          oldest_slot++;
          held--;
        end else begin
          expire = 1'b0;
        end
      end
      // Only a strictly larger occupancy becomes the new peak.
      if (held > peak_held) begin
        peak_held = held;
        peak_first = ring_ids[oldest_slot];
        peak_last = ring_ids[ADDR_W'(oldest_slot + held - 1)];
      end
    end
    rep.in_range = hit;
    rep.server_error = hit && (status >= ERROR_STATUS);
    rep.window_count = held;
    rep.peak_count = peak_held;
    rep.first_id = peak_first;
    rep.last_id = peak_last;
    rep.overflowed = dropped;
  endtask

  // Follow the configuration channel, the event side and the result side.
  always @(posedge clk) begin : watch
    report_t got;
    report_t want;
    if (rst) begin
      lo_bound = '0;
      hi_bound = '1;
      span = '0;
      oldest_slot = '0;
      held = '0;
      peak_held = '0;
      peak_first = '0;
      peak_last = '0;
      dropped = 1'b0;
      expected_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RANGE_START: lo_bound = cfg_data;
          REG_RANGE_END:   hi_bound = cfg_data;
          REG_WINDOW:      span = cfg_data[WIN_W-1:0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        got = {in_range, server_error, window_count, peak_count, peak_first_id, peak_last_id,
               overflowed};
        if (expected_reports.size() == 0) begin
          $error("result word popped with no event waiting for it");
          fail_tally++;
        end else begin
          want = expected_reports[0];
          expected_reports.delete(0);
          check_field("in_range", TIME_W'(want.in_range), TIME_W'(got.in_range));
          check_field("server_error", TIME_W'(want.server_error), TIME_W'(got.server_error));
          check_field("window_count", TIME_W'(want.window_count), TIME_W'(got.window_count));
          check_field("peak_count", TIME_W'(want.peak_count), TIME_W'(got.peak_count));
          check_field("peak_first_id", TIME_W'(want.first_id), TIME_W'(got.first_id));
          check_field("peak_last_id", TIME_W'(want.last_id), TIME_W'(got.last_id));
          check_field("overflowed", TIME_W'(want.overflowed), TIME_W'(got.overflowed));
        end
      end
      if (push && !full) begin
        advance_window(event_time, status_code, line_id, want);
        expected_reports.insert(expected_reports.size(), want);
      end
    end
    pending_reports <= expected_reports.size();
  end

endmodule

@@ test/tb_sliding_window_peak_rate_monitor_top.sv @@
module tb_sliding_window_peak_rate_monitor_top;
  import swpm_pkg::*;

  // Index that maps to no register; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam logic [TIME_W-1:0]   TIME_MAX   = '1;
  localparam logic [ID_W-1:0]     ID_MAX     = '1;
  localparam logic [STATUS_W-1:0] STATUS_MAX = '1;
  localparam logic [WIN_W-1:0]    SPAN_MAX   = '1;

  localparam int HOLD_CYCLES      = 300;
  localparam int STALL_LIMIT      = 10000;
  localparam int OVERFLOW_EVENTS  = WINDOW_DEPTH + 40;
  localparam int RANDOM_PHASES    = 6;
  localparam int EVENTS_PER_PHASE = 85;
  localparam int SETTLE_CYCLES    = 12;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  push = 1'b0;
  logic                  full;
  logic [TIME_W-1:0]     event_time = '0;
  logic [STATUS_W-1:0]   status_code = '0;
  logic [ID_W-1:0]       line_id = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic                  in_range;
  logic                  server_error;
  logic [CNT_W-1:0]      window_count;
  logic [CNT_W-1:0]      peak_count;
  logic [ID_W-1:0]       peak_first_id;
  logic [ID_W-1:0]       peak_last_id;
  logic                  overflowed;

  int pending_reports;
  int mismatches;

  // Idle rates in percent, and a toggle that asks the receiver for a long hold-off.
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  logic hold_toggle = 1'b0;

  logic [TIME_W-1:0] cur_time = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sliding_window_peak_rate_monitor_top u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push          (push),
    .full          (full),
    .event_time    (event_time),
    .status_code   (status_code),
    .line_id       (line_id),
    .empty         (empty),
    .pop           (pop),
    .in_range      (in_range),
    .server_error  (server_error),
    .window_count  (window_count),
    .peak_count    (peak_count),
    .peak_first_id (peak_first_id),
    .peak_last_id  (peak_last_id),
    .overflowed    (overflowed)
  );

  peak_rate_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .push            (push),
    .full            (full),
    .event_time      (event_time),
    .status_code     (status_code),
    .line_id         (line_id),
    .empty           (empty),
    .pop             (pop),
    .in_range        (in_range),
    .server_error    (server_error),
    .window_count    (window_count),
    .peak_count      (peak_count),
    .peak_first_id   (peak_first_id),
    .peak_last_id    (peak_last_id),
    .overflowed      (overflowed),
    .pending_reports (pending_reports),
    .mismatches      (mismatches)
  );

  // Offer one event word, with random idle cycles ahead of it, until it is taken.
  task automatic send_event(input logic [TIME_W-1:0] t, input logic [STATUS_W-1:0] status,
                            input logic [ID_W-1:0] id);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    event_time <= t;
    status_code <= status;
    line_id <= id;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Stop offering and wait until every expected result word has been popped.
  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk);
    while (pending_reports != 0) @(posedge clk);
  endtask

  // Leaves cfg_valid high so back-to-back writes need no gap.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input logic [TIME_W-1:0] lo, input logic [TIME_W-1:0] hi,
                           input logic [WIN_W-1:0] span);
    write_reg(REG_RANGE_START, lo);
    write_reg(REG_RANGE_END, hi);
    write_reg(REG_WINDOW, CFG_DATA_W'(span));
    cfg_valid <= 1'b0;
  endtask

  // Mostly advancing timestamps with bursts, jumps and a few steps backwards.
  task automatic send_random_event();
    int roll;
    logic [TIME_W-1:0] t;
    roll = $urandom_range(99);
    if (roll < 10 && cur_time > 10) begin
      t = cur_time - $urandom_range(1, 5);
    end else begin
      if (roll < 20) cur_time += $urandom_range(4, 60);
      else cur_time += $urandom_range(0, 3);
      t = cur_time;
    end
    send_event(t, STATUS_W'($urandom_range(0, STATUS_MAX)), $urandom);
  endtask

  // Pick a setting for one random phase: full or partial range, short, huge or no window.
  task automatic configure_random();
    int pick;
    logic [TIME_W-1:0] lo;
    pick = $urandom_range(0, 5);
    lo = cur_time + $urandom_range(0, 30);
    case (pick)
      0, 1: configure('0, TIME_MAX, $urandom_range(1, 40));
      2, 3: configure(lo, lo + $urandom_range(60, 300), $urandom_range(1, 40));
      4:    configure('0, TIME_MAX, (($urandom_range(1) == 0) ? SPAN_MAX : 1));
      default: configure(lo, lo + $urandom_range(60, 300), '0);
    endcase
  endtask

  // Receiver: random pop with an optional long hold-off counted here.
  initial begin : receiver
    int   hold_left;
    logic hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: give up when no word moves on any channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  // Stimulus and verdict.
  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Window disabled: field extremes and the error threshold.
    configure('0, TIME_MAX, '0);
    send_event('0, '0, '0);
    send_event(TIME_MAX, STATUS_MAX, ID_MAX);
    send_event(5, 499, 1);
    send_event(5, 500, 2);
    send_event(6, 999, 3);
    drain_results();

    // Widest window: equal times, a step backwards, and a jump that expires entries.
    write_reg(REG_UNUSED, '1);
    configure('0, TIME_MAX, SPAN_MAX);
    send_event(10, 200, 10);
    send_event(10, 503, 11);
    send_event(8, 404, 12);
    send_event(20, 500, 13);
    send_event(34'h1_0000_000A, 302, 14);
    send_event(TIME_MAX, 501, 15);
    drain_results();

    // An empty range accepts nothing; then both range bounds are inclusive.
    configure(100, 50, SPAN_MAX);
    send_event(75, 500, 20);
    send_event(100, 500, 21);
    send_event(50, 500, 22);
    drain_results();
    configure(100, 200, SPAN_MAX);
    send_event(99, 600, 23);
    send_event(100, 600, 24);
    send_event(200, 100, 25);
    send_event(201, 600, 26);
    drain_results();

    // Fill the ring past its depth so the oldest entries get dropped.
    configure('0, TIME_MAX, SPAN_MAX);
    cur_time = 1000;
    for (int i = 0; i < OVERFLOW_EVENTS; i++) begin
      if (i % 8 == 0) cur_time++;
      send_event(cur_time, STATUS_W'($urandom_range(0, STATUS_MAX)), $urandom);
    end
    drain_results();

    // Random phases under three idle patterns.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase / 2)
        0: begin
          tx_idle_pct = 27;
          rx_idle_pct = 56;
        end
        1: begin
          tx_idle_pct = 56;
          rx_idle_pct = 27;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      configure_random();
      // Back up the block once: the receiver holds off while events keep coming.
      if (phase == 0) hold_toggle = ~hold_toggle;
      for (int n = 0; n < EVENTS_PER_PHASE; n++) send_random_event();
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
